/* rtl/twg_pkg.sv */
package twg_pkg;

  // Field widths
  localparam int IDX_W    = 12;
  localparam int LEN_W    = 13;
  localparam int ALPHA_W  = 17;
  localparam int WEIGHT_W = 16;

  // Window lengths above this are used as this
  localparam int MAX_LENGTH = 4096;

  localparam int COS_DEPTH_DEFAULT = 1024;

  // Configuration register indexes
  localparam int          CFG_IDX_W  = 1;
  localparam logic [0:0]  CFG_TAPER  = 1'd0;
  localparam logic [0:0]  CFG_LENGTH = 1'd1;

  localparam logic [ALPHA_W-1:0]  TAPER_RESET  = 17'd32768;
  localparam logic [LEN_W-1:0]    LENGTH_RESET = 13'd2048;
  localparam logic [WEIGHT_W-1:0] ONE_Q15      = 16'd32768;

  // What the back end does with an item
  typedef logic [1:0] code_t;
  localparam code_t CODE_CALC = 2'd0;
  localparam code_t CODE_ONE  = 2'd1;
  localparam code_t CODE_ZERO = 2'd2;

endpackage

/* rtl/twg_front.sv */
module twg_front import twg_pkg::*; #(
  parameter int COS_TABLE_DEPTH = COS_DEPTH_DEFAULT,
  localparam int NUM_W = $clog2(8 * COS_TABLE_DEPTH) + IDX_W,
  localparam int DEN_W = LEN_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  logic [IDX_W-1:0]   sample_index,
  input  logic [ALPHA_W-1:0] taper_fraction,
  input  logic [LEN_W-1:0]   window_length,
  output logic               out_valid,
  output code_t              out_code,
  output logic [NUM_W-1:0]   out_num,
  output logic [DEN_W-1:0]   out_den
);

  localparam int EIGHT_D = 8 * COS_TABLE_DEPTH;
  localparam int FOUR_D  = 4 * COS_TABLE_DEPTH;

  // Stage A: clamp length, classify, taper product
  logic [LEN_W-1:0] n_clamp;
  code_t            code_a_next;
  logic [28:0]      prod_next;

  logic             a_valid;
  code_t            a_code;
  logic             a_hann;
  logic [IDX_W-1:0] a_i;
  logic [LEN_W-1:0] a_n;
  logic [28:0]      a_prod;

  always_comb begin
    n_clamp = (32'(window_length) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : window_length;
    if ({1'b0, sample_index} >= n_clamp) begin
      code_a_next = CODE_ZERO;
    end else if (taper_fraction == '0) begin
      code_a_next = CODE_ONE;
    end else begin
      code_a_next = CODE_CALC;
    end
    prod_next = 29'(taper_fraction[15:0]) * 29'(n_clamp - LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
    end
    if (advance) begin
      a_code <= code_a_next;
      a_hann <= taper_fraction[ALPHA_W-1];
      a_i    <= sample_index;
      a_n    <= n_clamp;
      a_prod <= prod_next;
    end
  end

  // Stage B: pick phase numerator and denominator, or reclassify as one
  logic [LEN_W-1:0] m;
  logic [11:0]      t;
  logic [LEN_W-1:0] n_minus_t;
  logic [IDX_W-1:0] j;
  logic             use_taper;
  code_t            code_b_next;
  logic [NUM_W-1:0] num_next;
  logic [DEN_W-1:0] den_next;

  always_comb begin
    m           = a_n - LEN_W'(1);
    t           = a_prod[28:17];
    n_minus_t   = a_n - {1'b0, t};
    j           = a_i;
    use_taper   = 1'b0;
    code_b_next = a_code;
    num_next    = '0;
    den_next    = '0;
    if (a_code == CODE_CALC) begin
      if (a_hann) begin
        if (m == '0) begin
          code_b_next = CODE_ONE;
        end else begin
          num_next = NUM_W'(EIGHT_D) * NUM_W'(a_i) + NUM_W'(m);
          den_next = DEN_W'({m, 1'b0});
        end
      end else if (t == '0) begin
        code_b_next = CODE_ONE;
      end else if (a_i < t) begin
        use_taper = 1'b1;
      end else if ({1'b0, a_i} >= n_minus_t) begin
        j         = IDX_W'(m - {1'b0, a_i});
        use_taper = 1'b1;
      end else begin
        code_b_next = CODE_ONE;
      end
      if (use_taper) begin
        num_next = NUM_W'(FOUR_D) * NUM_W'(j) + NUM_W'(t);
        den_next = DEN_W'({t, 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= a_valid;
    end
    if (advance) begin
      out_code <= code_b_next;
      out_num  <= num_next;
      out_den  <= den_next;
    end
  end

endmodule

/* rtl/twg_divider.sv */
module twg_divider import twg_pkg::*; #(
  parameter int COS_TABLE_DEPTH = COS_DEPTH_DEFAULT,
  localparam int NUM_W = $clog2(8 * COS_TABLE_DEPTH) + IDX_W,
  localparam int DEN_W = LEN_W + 1,
  localparam int QW    = $clog2(4 * COS_TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  code_t            in_code,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic             out_valid,
  output code_t            out_code,
  output logic [QW-1:0]    out_p
);

  // Restoring division, one quotient bit per stage. The quotient never
  // exceeds QW bits, so the partial remainder starts below the divisor.
  logic [DEN_W-1:0] rem   [QW];
  logic [DEN_W-1:0] den_r [QW];
  logic [QW-1:0]    qsh   [QW];
  code_t            code_r[QW];
  logic             v     [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [QW-1:0]    q_in;
    code_t            c_in;
    logic             v_in;
    logic [DEN_W:0]   trial;
    logic             fits;

    if (s == 0) begin : g_first
      assign r_in = DEN_W'(in_num >> QW);
      assign q_in = in_num[QW-1:0];
      assign d_in = in_den;
      assign c_in = in_code;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem[s-1];
      assign q_in = qsh[s-1];
      assign d_in = den_r[s-1];
      assign c_in = code_r[s-1];
      assign v_in = v[s-1];
    end

    assign trial = {r_in, q_in[QW-1]};
    assign fits  = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (advance) begin
        v[s] <= v_in;
      end
      if (advance) begin
        rem[s]    <= fits ? DEN_W'(trial - {1'b0, d_in}) : DEN_W'(trial);
        qsh[s]    <= {q_in[QW-2:0], fits};
        den_r[s]  <= d_in;
        code_r[s] <= c_in;
      end
    end
  end

  assign out_valid = v[QW-1];
  assign out_code  = code_r[QW-1];
  assign out_p     = qsh[QW-1];

endmodule

/* rtl/twg_weight.sv */
module twg_weight import twg_pkg::*; #(
  parameter int COS_TABLE_DEPTH = COS_DEPTH_DEFAULT,
  localparam int QW = $clog2(4 * COS_TABLE_DEPTH + 1),
  localparam int AW = $clog2(COS_TABLE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  code_t               in_code,
  input  logic [QW-1:0]       in_p,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WEIGHT_W-1:0] weight,
  output logic                out_of_range
);

  localparam int D = COS_TABLE_DEPTH;
  localparam longint D_L = COS_TABLE_DEPTH;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // cos(k*pi/(2D)) in Q1.15 from a truncated series in Q2.30
  function automatic logic [15:0] cos_entry(input int k);
    longint x;
    longint x2;
    longint r;
    x  = (longint'(k) * HALF_PI_Q30 + D_L / 2) / D_L;
    x2 = (x * x) >>> 30;
    r  = ONE_Q30;
    r  = ONE_Q30 - (x2 * r) / (ONE_Q30 * 182);
    r  = ONE_Q30 - (x2 * r) / (ONE_Q30 * 132);
    r  = ONE_Q30 - (x2 * r) / (ONE_Q30 * 90);
    r  = ONE_Q30 - (x2 * r) / (ONE_Q30 * 56);
    r  = ONE_Q30 - (x2 * r) / (ONE_Q30 * 30);
    r  = ONE_Q30 - (x2 * r) / (ONE_Q30 * 12);
    r  = ONE_Q30 - (x2 * r) / (ONE_Q30 * 2);
    if (r < 0) r = 0;
    if (r > ONE_Q30) r = ONE_Q30;
    return 16'((r + 64'sd16384) >>> 15);
  endfunction

  logic [15:0] cos_rom [D+1];

  for (genvar k = 0; k <= D; k++) begin : g_rom
    localparam logic [15:0] ENTRY = cos_entry(k);
    assign cos_rom[k] = ENTRY;
  end

  // Stage F: quarter-wave fold
  int unsigned     pc;
  logic [AW-1:0]   addr_next;
  logic            neg_next;

  logic            f_valid;
  logic [AW-1:0]   f_addr;
  logic            f_neg;
  code_t           f_code;

  always_comb begin
    pc = (32'(in_p) > 4 * D) ? 4 * D : 32'(in_p);
    if (pc <= D) begin
      addr_next = AW'(pc);
      neg_next  = 1'b0;
    end else if (pc <= 2 * D) begin
      addr_next = AW'(2 * D - pc);
      neg_next  = 1'b1;
    end else if (pc <= 3 * D) begin
      addr_next = AW'(pc - 2 * D);
      neg_next  = 1'b1;
    end else begin
      addr_next = AW'(4 * D - pc);
      neg_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (advance) begin
      f_valid <= in_valid;
    end
    if (advance) begin
      f_addr <= addr_next;
      f_neg  <= neg_next;
      f_code <= in_code;
    end
  end

  // Stage R: table read
  logic        r_valid;
  logic [15:0] rom_q;
  logic        r_neg;
  code_t       r_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= f_valid;
    end
    if (advance) begin
      rom_q  <= cos_rom[f_addr];
      r_neg  <= f_neg;
      r_code <= f_code;
    end
  end

  // Raised cosine: (1 - c + 1) >> 1 in Q1.15
  logic [16:0]          w17;
  logic [WEIGHT_W-1:0]  w_final;
  logic                 oor_final;

  always_comb begin
    w17 = r_neg ? 17'(ONE_Q15) + 17'd1 + 17'(rom_q)
                : 17'(ONE_Q15) + 17'd1 - 17'(rom_q);
    case (r_code)
      CODE_CALC: w_final = w17[16:1];
      CODE_ONE:  w_final = ONE_Q15;
      default:   w_final = '0;
    endcase
    oor_final = (r_code == CODE_ZERO);
  end

  // Output register with one skid entry
  logic                skid_valid;
  logic [WEIGHT_W-1:0] skid_weight;
  logic                skid_oor;
  logic                out_take;

  assign out_take = out_valid && !out_stall;
  assign advance  = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        weight       <= skid_weight;
        out_of_range <= skid_oor;
        skid_valid   <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid    <= r_valid;
      weight       <= w_final;
      out_of_range <= oor_final;
    end else if (r_valid) begin
      // hold the waiting result, park the new one
      skid_valid  <= 1'b1;
      skid_weight <= w_final;
      skid_oor    <= oor_final;
    end
  end

endmodule

/* rtl/tukey_window_generator_top.sv */
// Tukey window weight generator, one weight per sample index.
// Data passes front stages A and B, divider stages, fold F, read R and the
// output register; QW, the phase width, is clog2(4*COS_TABLE_DEPTH+1).
// Throughput: one transaction per cycle while in_stall is low.
// A one-entry skid behind the output register absorbs an output stall.
// Reset (rst, synchronous): clears all valid bits and loads register defaults.
module tukey_window_generator_top import twg_pkg::*; #(
  parameter int COS_TABLE_DEPTH = COS_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ALPHA_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IDX_W-1:0]     sample_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WEIGHT_W-1:0]  weight,
  output logic                 out_of_range
);

  localparam int NUM_W = $clog2(8 * COS_TABLE_DEPTH) + IDX_W;
  localparam int DEN_W = LEN_W + 1;
  localparam int QW    = $clog2(4 * COS_TABLE_DEPTH + 1);

  logic [ALPHA_W-1:0] taper_fraction;
  logic [LEN_W-1:0]   window_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      taper_fraction <= TAPER_RESET;
      window_length  <= LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TAPER:  taper_fraction <= cfg_data;
        CFG_LENGTH: window_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic             advance;
  logic             fr_valid;
  code_t            fr_code;
  logic [NUM_W-1:0] fr_num;
  logic [DEN_W-1:0] fr_den;
  logic             dv_valid;
  code_t            dv_code;
  logic [QW-1:0]    dv_p;

  assign in_stall = !advance;

  twg_front #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .in_valid       (in_valid),
    .sample_index   (sample_index),
    .taper_fraction (taper_fraction),
    .window_length  (window_length),
    .out_valid      (fr_valid),
    .out_code       (fr_code),
    .out_num        (fr_num),
    .out_den        (fr_den)
  );

  twg_divider #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (fr_valid),
    .in_code   (fr_code),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .out_valid (dv_valid),
    .out_code  (dv_code),
    .out_p     (dv_p)
  );

  twg_weight #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_weight (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dv_valid),
    .in_code      (dv_code),
    .in_p         (dv_p),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .weight       (weight),
    .out_of_range (out_of_range)
  );

endmodule

/* rtl/twg_checker.sv */
module twg_checker import twg_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [WEIGHT_W-1:0]  weight,
  input logic                 out_of_range
);

  // Out-of-range transactions carry a zero weight
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> weight == '0)
    else $error("out_of_range with nonzero weight");

  a_weight_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> weight <= ONE_Q15)
    else $error("weight above 1.0");

  // The skid drains once the output is not stalled, freeing the input in the next cycle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    !out_stall |=> !in_stall)
    else $error("input stalled after output was free");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(weight) && $stable(out_of_range))
    else $error("stalled output changed");

endmodule

bind tukey_window_generator_top twg_checker u_checker (.*);

/* test/tukey_window_generator_top_tb.sv */
`timescale 1ns / 1ps

module tukey_window_generator_top_tb;
  import twg_pkg::*;

  localparam int COS_DEPTH    = COS_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                out_of_range;
  } window_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ALPHA_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [IDX_W-1:0]     sample_index;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WEIGHT_W-1:0]  weight;
  logic                 out_of_range;

  // Shadow copies of the configuration registers
  logic [ALPHA_W-1:0]   cur_taper;
  logic [LEN_W-1:0]     cur_length;

  int unsigned          cos_q15 [0:COS_DEPTH];
  window_result_t       pending_weights [$];
  window_result_t       want_result;
  int unsigned          mismatches = 0;
  int unsigned          items_sent = 0;
  int unsigned          cycles = 0;
  int unsigned          stall_left = 0;
  bit                   quiet = 1'b0;
  bit                   calm = 1'b0;

  tukey_window_generator_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_index (sample_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .weight       (weight),
    .out_of_range (out_of_range)
  );

  always #1 clk = ~clk;

  // Quarter-wave cosine table from a Taylor series in Q2.30
  function automatic void build_cos_table();
    longint x;
    longint x2;
    longint r;
    longint dv;
    for (int k = 0; k <= COS_DEPTH; k++) begin
      x = (longint'(k) * 64'd1686629713 + COS_DEPTH / 2) / COS_DEPTH;
      x2 = (x * x) >>> 30;
      r = 64'd1073741824;
      for (int n = 7; n >= 1; n--) begin
        dv = 64'd1073741824 * (2 * n) * (2 * n - 1);
        r = 64'd1073741824 - (x2 * r) / dv;
      end
      if (r < 0) r = 0;
      if (r > 64'd1073741824) r = 64'd1073741824;
      cos_q15[k] = int'((r + 16384) >>> 15);
    end
  endfunction

  // Phase counts 4*COS_DEPTH steps per turn
  function automatic int cos_at(longint p);
    if (p > 4 * COS_DEPTH) p = 4 * COS_DEPTH;
    if (p <= COS_DEPTH) return int'(cos_q15[p]);
    if (p <= 2 * COS_DEPTH) return -int'(cos_q15[2 * COS_DEPTH - p]);
    if (p <= 3 * COS_DEPTH) return -int'(cos_q15[p - 2 * COS_DEPTH]);
    return int'(cos_q15[4 * COS_DEPTH - p]);
  endfunction

  function automatic logic [WEIGHT_W-1:0] raised_cosine(longint p);
    int c;
    c = cos_at(p);
    return WEIGHT_W'((32768 - c + 1) >>> 1);
  endfunction

  function automatic window_result_t tukey_weight(logic [IDX_W-1:0] idx);
    longint i;
    longint n;
    longint a;
    longint m;
    longint t;
    window_result_t res;
    i = idx;
    n = cur_length;
    a = cur_taper;
    if (n > MAX_LENGTH) n = MAX_LENGTH;
    res.weight = ONE_Q15;
    res.out_of_range = 1'b0;
    if (i >= n) begin
      res.weight = '0;
      res.out_of_range = 1'b1;
    end else if (a >= 65536) begin
      m = n - 1;
      if (m != 0) res.weight = raised_cosine((8 * COS_DEPTH * i + m) / (2 * m));
    end else if (a != 0) begin
      t = (a * (n - 1)) >>> 17;
      if (t != 0 && i < t) begin
        res.weight = raised_cosine((4 * COS_DEPTH * i + t) / (2 * t));
      end else if (t != 0 && i >= n - t) begin
        res.weight = raised_cosine((4 * COS_DEPTH * (n - 1 - i) + t) / (2 * t));
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch: %s expected %0d got %0d (taper %0d length %0d)",
             what, want, got, cur_taper, cur_length);
    mismatches++;
  endtask

  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    gap = 0;
    if (!quiet && !calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_weights.push_back(tukey_weight(idx));
    items_sent++;
  endtask

  // Drop valid after the last transaction of a phase, then wait for every result
  task automatic drain_window();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_TAPER) cur_taper = data;
    else cur_length = data[LEN_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_index(12'd0);
    send_index(12'd4095);
    send_index(12'd2047);
    send_index(12'd511);
    drain_window();
  endtask

  task automatic test_hann();
    write_reg(CFG_TAPER, 17'd65536);
    write_reg(CFG_LENGTH, 17'd4096);
    send_index(12'd0);
    send_index(12'd1);
    send_index(12'd2047);
    send_index(12'd4095);
    drain_window();
    // alpha above one still selects Hann
    write_reg(CFG_TAPER, 17'h1FFFF);
    write_reg(CFG_LENGTH, 17'd13);
    send_index(12'd0);
    send_index(12'd6);
    send_index(12'd12);
    send_index(12'd13);
    drain_window();
  endtask

  task automatic test_flat_windows();
    write_reg(CFG_TAPER, 17'd0);
    write_reg(CFG_LENGTH, 17'd200);
    send_index(12'd0);
    send_index(12'd100);
    send_index(12'd200);
    drain_window();
    // taper rounds down to zero length
    write_reg(CFG_TAPER, 17'd1);
    write_reg(CFG_LENGTH, 17'd4096);
    send_index(12'd0);
    drain_window();
  endtask

  task automatic test_length_extremes();
    write_reg(CFG_TAPER, 17'd32768);
    write_reg(CFG_LENGTH, 17'h1FFFF);
    send_index(12'd4095);
    drain_window();
    write_reg(CFG_LENGTH, 17'd0);
    send_index(12'd0);
    drain_window();
    write_reg(CFG_LENGTH, 17'd1);
    send_index(12'd0);
    drain_window();
    write_reg(CFG_TAPER, 17'd65536);
    send_index(12'd0);
    send_index(12'd1);
    drain_window();
  endtask

  task automatic test_random_windows();
    logic [ALPHA_W-1:0] taper_val;
    logic [LEN_W-1:0]   length_val;
    int                 phase_items;
    int                 which;
    longint             n_eff;
    longint             t;
    longint             v;
    while (items_sent < RANDOM_ITEMS + 30) begin
      case ($urandom_range(0, 9))
        0:       taper_val = 17'd0;
        1:       taper_val = 17'd65536;
        2:       taper_val = $urandom_range(65536, 131071);
        3:       taper_val = $urandom_range(1, 7);
        4:       taper_val = 17'd65535;
        default: taper_val = $urandom_range(1, 65535);
      endcase
      case ($urandom_range(0, 9))
        0:       length_val = $urandom_range(2, 20);
        1:       length_val = $urandom_range(0, 1);
        2:       length_val = $urandom_range(4097, 8191);
        3:       length_val = 13'd4096;
        4:       length_val = 13'd2;
        default: length_val = $urandom_range(2, 4096);
      endcase
      which = $urandom_range(0, 3);
      // bits above the length field are ignored by the register
      if (which != 1) write_reg(CFG_LENGTH, {4'($urandom), length_val});
      if (which != 2) write_reg(CFG_TAPER, taper_val);
      calm = ($urandom_range(0, 3) == 0);
      n_eff = cur_length;
      if (n_eff > MAX_LENGTH) n_eff = MAX_LENGTH;
      t = 0;
      if (cur_taper != 0 && cur_taper < 65536 && n_eff > 0)
        t = (longint'(cur_taper) * (n_eff - 1)) >>> 17;
      phase_items = $urandom_range(20, 120);
      for (int k = 0; k < phase_items; k++) begin
        quiet = (items_sent >= RANDOM_ITEMS - QUIET_ITEMS);
        case ($urandom_range(0, 5))
          0: v = $urandom_range(0, 4095);
          1: begin
            case ($urandom_range(0, 7))
              0: v = t - 1;
              1: v = t;
              2: v = t + 1;
              3: v = n_eff - t - 1;
              4: v = n_eff - t;
              5: v = n_eff - 1;
              6: v = n_eff;
              default: v = 0;
            endcase
          end
          default: v = (n_eff > 0) ? $urandom_range(0, int'(n_eff) - 1) : $urandom_range(0, 4095);
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        send_index(IDX_W'(v));
      end
      drain_window();
    end
  endtask

  always @(negedge clk) begin
    if (rst || quiet || calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("result with nothing pending, weight", 0, weight);
      end else begin
        want_result = pending_weights.pop_front();
        if (weight !== want_result.weight)
          report_mismatch("weight", want_result.weight, weight);
        if (out_of_range !== want_result.out_of_range)
          report_mismatch("out_of_range", want_result.out_of_range, out_of_range);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    sample_index = '0;
    cfg_write    = 1'b0;
    cfg_index    = CFG_TAPER;
    cfg_data     = '0;
    cur_taper    = TAPER_RESET;
    cur_length   = LENGTH_RESET;
    build_cos_table();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_hann();
    test_flat_windows();
    test_length_extremes();
    test_random_windows();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_weights.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
